FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, idle during rst.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, idle during rst.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ips_pkg.sv
package ips_pkg;

  localparam int ADC_BITS           = 10;
  localparam int COUNT_BITS         = 12;
  localparam int SUM_W              = ADC_BITS + COUNT_BITS;
  localparam int CAL_CYCLES_DEFAULT = 10;
  localparam int QDEPTH             = 2;

  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

  // Register reset values
  localparam logic [COUNT_BITS-1:0] AMBIENT_SAMPLES_RST = COUNT_BITS'(700);
  localparam logic [COUNT_BITS-1:0] DEAD_TICKS_RST      = COUNT_BITS'(10);
  localparam logic [COUNT_BITS-1:0] IR_SAMPLES_RST      = COUNT_BITS'(200);
  localparam logic [ADC_BITS-1:0]   TOLERANCE_RST       = ADC_BITS'(5);

  typedef enum logic [1:0] {
    CFG_AMBIENT_SAMPLES,
    CFG_DEAD_TICKS,
    CFG_IR_SAMPLES,
    CFG_TOLERANCE
  } cfg_idx_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] ambient_samples;
    logic [COUNT_BITS-1:0] dead_ticks;
    logic [COUNT_BITS-1:0] lit_samples;
    logic [ADC_BITS-1:0]   tolerance;
  } cfg_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] adc_sample;
    logic                start_calibration;
  } sample_t;

  typedef struct packed {
    logic                led_on;
    logic [ADC_BITS-1:0] ambient_level;
    logic [ADC_BITS-1:0] ir_level;
    logic [ADC_BITS-1:0] proximity;
    logic [ADC_BITS-1:0] baseline_delta;
    logic                calibrating;
    logic                cycle_done;
  } result_t;

  typedef enum logic [1:0] {
    PH_AMBIENT,
    PH_DEAD,
    PH_IR,
    PH_CLOSE
  } phase_t;

  // Work kinds handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_AMB,
    OP_LATCH_AMB,
    OP_DEAD,
    OP_IR,
    OP_CLOSE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ADC_BITS-1:0] adc;
    logic                cal;
  } qent_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV_AMB,
    B_DIV_IR,
    B_CAL,
    B_DIV_CAL,
    B_OUT
  } bstate_t;

  // A zero count acts as one
  function automatic logic [COUNT_BITS-1:0] eff_count(input logic [COUNT_BITS-1:0] c);
    eff_count = (c == '0) ? COUNT_BITS'(1) : c;
  endfunction

  // Phase ends when the bumped count wraps or reaches the limit
  function automatic logic count_reached(input logic [COUNT_BITS-1:0] tk_inc,
                                         input logic [COUNT_BITS-1:0] lim);
    count_reached = (tk_inc == '0) || (tk_inc >= eff_count(lim));
  endfunction

endpackage

FILE: sv/ips_queue.sv
module ips_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ips_pkg::qent_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output ips_pkg::qent_t pop_data
);
  import ips_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  qent_t             mem [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/ips_div.sv
module ips_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ips_pkg::SUM_W-1:0]      dividend,
  input  logic [ips_pkg::COUNT_BITS-1:0] divisor,
  output logic                           done,
  output logic [ips_pkg::SUM_W-1:0]      quotient
);
  import ips_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  ge;
  logic [COUNT_BITS:0]   rem_sub;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem, quotient[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = ge ? (rem_sh - {1'b0, dvs}) : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], ge};
      rem      <= rem_sub[COUNT_BITS-1:0];
    end
  end

endmodule

FILE: sv/ips_front.sv
module ips_front (
  input  logic             clk,
  input  logic             rst,
  input  ips_pkg::cfg_t    cfg,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  ips_pkg::sample_t sample,
  output logic             push_valid,
  input  logic             push_ready,
  output ips_pkg::qent_t   push_data
);
  import ips_pkg::*;

  phase_t                phase;
  phase_t                phase_next;
  logic [COUNT_BITS-1:0] tick_count;
  logic [COUNT_BITS-1:0] tick_count_next;
  phase_t                ph;
  logic [COUNT_BITS-1:0] tk;
  logic [COUNT_BITS-1:0] tk_inc;
  logic                  take;

  assign sample_ready = push_ready;
  assign push_valid   = sample_valid;
  assign take         = sample_valid && push_ready;

  // A calibration request restarts the cycle before this tick is classified
  assign ph     = sample.start_calibration ? PH_AMBIENT : phase;
  assign tk     = sample.start_calibration ? '0 : tick_count;
  assign tk_inc = tk + COUNT_BITS'(1);

  // Next phase and tick count
  always_comb begin
    phase_next      = ph;
    tick_count_next = tk_inc;
    case (ph)
      PH_AMBIENT: begin
        if (count_reached(tk_inc, cfg.ambient_samples)) begin
          phase_next      = PH_DEAD;
          tick_count_next = '0;
        end
      end
      PH_DEAD: begin
        if (count_reached(tk_inc, cfg.dead_ticks)) begin
          phase_next      = PH_IR;
          tick_count_next = '0;
        end
      end
      PH_IR: begin
        if (count_reached(tk_inc, cfg.lit_samples)) begin
          phase_next = PH_CLOSE;
        end
      end
      PH_CLOSE: begin
        phase_next      = PH_AMBIENT;
        tick_count_next = '0;
      end
      default: begin
        phase_next      = PH_AMBIENT;
        tick_count_next = '0;
      end
    endcase
  end

  // Classify the tick for the back end
  always_comb begin
    push_data.adc = sample.adc_sample;
    push_data.cal = sample.start_calibration;
    case (ph)
      PH_AMBIENT: push_data.op = OP_AMB;
      PH_DEAD:    push_data.op = (tk == '0) ? OP_LATCH_AMB : OP_DEAD;
      PH_IR:      push_data.op = OP_IR;
      PH_CLOSE:   push_data.op = OP_CLOSE;
      default:    push_data.op = OP_AMB;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_AMBIENT;
      tick_count <= '0;
    end else if (take) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

FILE: sv/ips_back.sv
module ips_back #(
  parameter int CAL_CYCLES = ips_pkg::CAL_CYCLES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  ips_pkg::cfg_t    cfg,
  input  logic             q_valid,
  output logic             q_pop,
  input  ips_pkg::qent_t   q_data,
  output logic             result_valid,
  input  logic             result_ready,
  output ips_pkg::result_t result
);
  import ips_pkg::*;

  localparam int LEFT_W = $clog2(CAL_CYCLES + 1);
  localparam int TOT_W  = ADC_BITS + LEFT_W;
  // Reciprocal of CAL_CYCLES, exact for every TOT_W-bit total
  localparam int CAL_SH = TOT_W + $clog2(CAL_CYCLES);
  localparam int MUL_W  = CAL_SH + 1;
  localparam logic [MUL_W-1:0] CAL_MUL =
    MUL_W'(((1 << CAL_SH) + CAL_CYCLES - 1) / CAL_CYCLES);

  bstate_t             state;
  bstate_t             state_next;
  op_t                 op;
  op_t                 op_next;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic [ADC_BITS-1:0] amb;
  logic [ADC_BITS-1:0] amb_next;
  logic [ADC_BITS-1:0] ir;
  logic [ADC_BITS-1:0] ir_next;
  logic [ADC_BITS-1:0] base;
  logic [ADC_BITS-1:0] base_next;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    total_next;
  logic [LEFT_W-1:0]   left;
  logic [LEFT_W-1:0]   left_next;

  logic                  div_start;
  logic [SUM_W-1:0]      div_dividend;
  logic [COUNT_BITS-1:0] div_divisor;
  logic                  div_done;
  logic [SUM_W-1:0]      div_q;
  logic [ADC_BITS-1:0]   div_sat;

  logic [TOT_W+MUL_W-1:0] cal_prod;

  logic [ADC_BITS-1:0] delta;
  logic [ADC_BITS-1:0] diff;
  logic [ADC_BITS-1:0] prox;
  logic                res_load;

  ips_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Averages saturate at full scale
  assign div_sat = (div_q > SUM_W'(ADC_MAX)) ? ADC_MAX : div_q[ADC_BITS-1:0];

  // Baseline mean of the calibration total
  assign cal_prod = {{MUL_W{1'b0}}, total} * {{TOT_W{1'b0}}, CAL_MUL};

  // Emitter on/off difference and proximity
  assign delta = (amb >= ir) ? (amb - ir) : (ir - amb);
  assign diff  = delta - base;
  assign prox  = ((delta < base) || (diff < cfg.tolerance)) ? '0 : diff;

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          case (q_data.op)
            OP_LATCH_AMB: state_next = B_DIV_AMB;
            OP_CLOSE:     state_next = B_DIV_IR;
            default:      state_next = B_OUT;
          endcase
        end
      end
      B_DIV_AMB: if (div_done) state_next = B_OUT;
      B_DIV_IR:  if (div_done) state_next = B_CAL;
      B_CAL:     state_next = (left == LEFT_W'(1)) ? B_DIV_CAL : B_OUT;
      B_DIV_CAL: state_next = B_OUT;
      B_OUT:     if (!result_valid || result_ready) state_next = B_IDLE;
      default:   state_next = B_IDLE;
    endcase
  end

  // Datapath updates and divider control
  always_comb begin
    logic [SUM_W-1:0] s;
    s            = sum;
    op_next      = op;
    sum_next     = sum;
    amb_next     = amb;
    ir_next      = ir;
    base_next    = base;
    total_next   = total;
    left_next    = left;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = sum;
    div_divisor  = eff_count(cfg.ambient_samples);
    res_load     = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          op_next = q_data.op;
          // Calibration request clears all levels first
          if (q_data.cal) begin
            s          = '0;
            amb_next   = '0;
            ir_next    = '0;
            base_next  = '0;
            total_next = '0;
            left_next  = LEFT_W'(CAL_CYCLES);
          end
          sum_next = s;
          if (q_data.op inside {OP_AMB, OP_IR}) begin
            sum_next = s + SUM_W'(q_data.adc);
          end else if (q_data.op == OP_LATCH_AMB) begin
            div_start    = 1'b1;
            div_dividend = s;
            div_divisor  = eff_count(cfg.ambient_samples);
          end else if (q_data.op == OP_CLOSE) begin
            div_start    = 1'b1;
            div_dividend = s;
            div_divisor  = eff_count(cfg.lit_samples);
          end
        end
      end
      B_DIV_AMB: begin
        if (div_done) begin
          amb_next = div_sat;
          sum_next = '0;
        end
      end
      B_DIV_IR: begin
        if (div_done) begin
          ir_next  = div_sat;
          sum_next = '0;
        end
      end
      B_CAL: begin
        // Fold this cycle's delta into the baseline total
        if (left != '0) begin
          total_next = total + TOT_W'(delta);
          left_next  = left - LEFT_W'(1);
        end
      end
      B_DIV_CAL: begin
        // Take the truncated mean of the finished total
        base_next = cal_prod[CAL_SH +: ADC_BITS];
      end
      B_OUT: begin
        res_load = !result_valid || result_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      op    <= OP_AMB;
      sum   <= '0;
      amb   <= '0;
      ir    <= '0;
      base  <= '0;
      total <= '0;
      left  <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      sum   <= sum_next;
      amb   <= amb_next;
      ir    <= ir_next;
      base  <= base_next;
      total <= total_next;
      left  <= left_next;
    end
  end

  // Output register: hold the result until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.led_on         <= (op == OP_IR);
      result.ambient_level  <= amb;
      result.ir_level       <= ir;
      result.proximity      <= prox;
      result.baseline_delta <= base;
      result.calibrating    <= (left != '0);
      result.cycle_done     <= (op == OP_CLOSE);
    end
  end

endmodule

FILE: sv/ir_proximity_sampler.sv
// Channel   Direction  Handshake                 Payload
// sample    in         sample_valid/sample_ready sample_t: adc_sample, start_calibration
// result    out        result_valid/result_ready result_t: one result per sample
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data (ready always high)
//
// Plain ticks are applied in the back-end sequencer, then their result is loaded;
// the tick that latches the ambient average adds a bit-serial divider pass, and
// the closing tick adds a divider pass and a calibration step, plus the baseline
// mean on the last calibration cycle. A 2-entry queue separates classification
// from the back end; stalls on result hold the sequencer in its output state.
// Reset is synchronous; it skips queue storage, divider data and result payload.
module ir_proximity_sampler #(
  parameter int CAL_CYCLES = ips_pkg::CAL_CYCLES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  ips_pkg::sample_t               sample,
  output logic                           result_valid,
  input  logic                           result_ready,
  output ips_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  ips_pkg::cfg_idx_t              cfg_index,
  input  logic [ips_pkg::COUNT_BITS-1:0] cfg_data
);
  import ips_pkg::*;

  cfg_t  cfg;
  logic  push_valid;
  logic  push_ready;
  qent_t push_data;
  logic  q_valid;
  logic  q_pop;
  qent_t q_data;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ambient_samples <= AMBIENT_SAMPLES_RST;
      cfg.dead_ticks      <= DEAD_TICKS_RST;
      cfg.lit_samples     <= IR_SAMPLES_RST;
      cfg.tolerance       <= TOLERANCE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AMBIENT_SAMPLES: cfg.ambient_samples <= cfg_data;
        CFG_DEAD_TICKS:      cfg.dead_ticks      <= cfg_data;
        CFG_IR_SAMPLES:      cfg.lit_samples     <= cfg_data;
        CFG_TOLERANCE:       cfg.tolerance       <= cfg_data[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  ips_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  ips_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  ips_back #(
    .CAL_CYCLES (CAL_CYCLES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_data       (q_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: sv/ips_checker.sv
`include "assert_macros.svh"

module ips_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input ips_pkg::result_t result
);
  import ips_pkg::*;

  // A stalled result holds
  `ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

  // Emitter is never on during the closing tick
  `ASSERT_NOW(a_led_close, result_valid && result.led_on, !result.cycle_done, "led on at cycle close")

  // Nonzero proximity needs a nonzero difference
  `ASSERT_NOW(a_prox_delta, result_valid && (result.proximity != '0), result.ambient_level != result.ir_level, "proximity without delta")

  // Baseline reads zero while calibrating
  `ASSERT_NOW(a_cal_base, result_valid && result.calibrating, result.baseline_delta == '0, "baseline set during calibration")

endmodule

bind ir_proximity_sampler ips_checker u_ips_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ips_pkg::*;

  localparam int CAL_N = CAL_CYCLES_DEFAULT;
  localparam int LIMIT = 1_000_000;
  localparam int TAIL  = 60;

  // Tracks the sensor's cycle and queues the reading each tick should produce
  class proximity_tracker;
    logic [COUNT_BITS-1:0] amb_cnt, dead_cnt, ir_cnt;
    logic [ADC_BITS-1:0]   tol;
    phase_t                ph;
    logic [COUNT_BITS-1:0] ticks;
    logic [SUM_W-1:0]      acc;
    logic [ADC_BITS-1:0]   amb_avg, ir_lvl, base;
    int unsigned           cal_acc;
    logic [3:0]            cal_left;
    result_t               due[$];
    int unsigned           errors, checked, taken, closed, cal_runs, writes;

    function new();
      amb_cnt  = AMBIENT_SAMPLES_RST;
      dead_cnt = DEAD_TICKS_RST;
      ir_cnt   = IR_SAMPLES_RST;
      tol      = TOLERANCE_RST;
      ph       = PH_AMBIENT;
      ticks    = '0;
      acc      = '0;
      amb_avg  = '0;
      ir_lvl   = '0;
      base     = '0;
      cal_acc  = 0;
      cal_left = '0;
    endfunction

    function logic [COUNT_BITS-1:0] count_limit(logic [COUNT_BITS-1:0] c);
      return (c == '0) ? COUNT_BITS'(1) : c;
    endfunction

    // Truncated mean, clipped at full scale
    function logic [ADC_BITS-1:0] mean_of(logic [SUM_W-1:0] total,
                                          logic [COUNT_BITS-1:0] cnt);
      logic [SUM_W-1:0] q;
      q = total / count_limit(cnt);
      return (q > SUM_W'(ADC_MAX)) ? ADC_MAX : q[ADC_BITS-1:0];
    endfunction

    function logic [ADC_BITS-1:0] level_gap();
      return (amb_avg >= ir_lvl) ? amb_avg - ir_lvl : ir_lvl - amb_avg;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [COUNT_BITS-1:0] val);
      case (idx)
        CFG_AMBIENT_SAMPLES: amb_cnt = val;
        CFG_DEAD_TICKS:      dead_cnt = val;
        CFG_IR_SAMPLES:      ir_cnt = val;
        default:             tol = val[ADC_BITS-1:0];
      endcase
      writes++;
    endfunction

    // Advance one tick and queue the reading it produces
    function void log_tick(sample_t s);
      result_t             r;
      logic [ADC_BITS-1:0] gap;
      r = '0;
      taken++;
      // A calibration request restarts the cycle before the tick is used
      if (s.start_calibration) begin
        ph       = PH_AMBIENT;
        ticks    = '0;
        acc      = '0;
        amb_avg  = '0;
        ir_lvl   = '0;
        base     = '0;
        cal_acc  = 0;
        cal_left = 4'(CAL_N);
      end
      case (ph)
        PH_AMBIENT: begin
          acc   = acc + SUM_W'(s.adc_sample);
          ticks = ticks + COUNT_BITS'(1);
          if (ticks == '0 || ticks >= count_limit(amb_cnt)) begin
            ph    = PH_DEAD;
            ticks = '0;
          end
        end
        PH_DEAD: begin
          if (ticks == '0) begin
            amb_avg = mean_of(acc, amb_cnt);
            acc     = '0;
          end
          ticks = ticks + COUNT_BITS'(1);
          if (ticks == '0 || ticks >= count_limit(dead_cnt)) begin
            ph    = PH_IR;
            ticks = '0;
          end
        end
        PH_IR: begin
          r.led_on = 1'b1;
          acc      = acc + SUM_W'(s.adc_sample);
          ticks    = ticks + COUNT_BITS'(1);
          if (ticks == '0 || ticks >= count_limit(ir_cnt)) ph = PH_CLOSE;
        end
        default: begin
          ir_lvl       = mean_of(acc, ir_cnt);
          acc          = '0;
          ticks        = '0;
          ph           = PH_AMBIENT;
          r.cycle_done = 1'b1;
          closed++;
          if (cal_left != '0) begin
            cal_acc  = cal_acc + 32'(level_gap());
            cal_left = cal_left - 4'(1);
            if (cal_left == '0) begin
              base = ADC_BITS'(cal_acc / CAL_N);
              cal_runs++;
            end
          end
        end
      endcase
      gap = level_gap();
      if (gap < base || gap - base < tol) r.proximity = '0;
      else r.proximity = gap - base;
      r.ambient_level  = amb_avg;
      r.ir_level       = ir_lvl;
      r.baseline_delta = base;
      r.calibrating    = (cal_left != '0);
      due.push_back(r);
    endfunction

    function void compare_field(string name, logic [ADC_BITS-1:0] want,
                                logic [ADC_BITS-1:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Match an accepted reading against the oldest one queued
    function void match_reading(result_t got);
      result_t want;
      if (due.size() == 0) begin
        $error("reading with no sample pending: %p", got);
        errors++;
        return;
      end
      want = due.pop_front();
      checked++;
      compare_field("led_on", want.led_on, got.led_on);
      compare_field("ambient_level", want.ambient_level, got.ambient_level);
      compare_field("ir_level", want.ir_level, got.ir_level);
      compare_field("proximity", want.proximity, got.proximity);
      compare_field("baseline_delta", want.baseline_delta, got.baseline_delta);
      compare_field("calibrating", want.calibrating, got.calibrating);
      compare_field("cycle_done", want.cycle_done, got.cycle_done);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  sample_t               sample = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_AMBIENT_SAMPLES;
  logic [COUNT_BITS-1:0] cfg_data = '0;

  bit                    calm = 1'b0;
  int unsigned           cycle_count = 0;
  proximity_tracker      book = new();

  ir_proximity_sampler #(.CAL_CYCLES(CAL_N)) dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watch every transfer on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) book.set_reg(cfg_index, cfg_data);
      if (sample_valid && sample_ready) book.log_tick(sample);
      if (result_valid && result_ready) book.match_reading(result);
    end
  end

  // Stall the reading side at random, except during the calm stretch
  always @(negedge clk) begin
    result_ready <= calm || ($urandom_range(0, 99) >= 26);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("cycle limit reached with %0d readings outstanding", book.due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Drop valid and hold until every queued reading has arrived
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (book.due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [COUNT_BITS-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Present one tick; valid stays high afterward until the next decision
  task automatic send_sample(input logic [ADC_BITS-1:0] adc, input logic cal);
    while (!calm && $urandom_range(0, 99) < 26) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= sample_t'{adc_sample: adc, start_calibration: cal};
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [COUNT_BITS-1:0] val;
    logic [ADC_BITS-1:0]   lo, hi, adc;
    cfg_idx_t              idx;
    int                    sel;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Short cycle with zero tolerance, full-scale and zero samples
    write_reg(CFG_AMBIENT_SAMPLES, 12'd2);
    write_reg(CFG_DEAD_TICKS, 12'd1);
    write_reg(CFG_IR_SAMPLES, 12'd2);
    write_reg(CFG_TOLERANCE, 12'd0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd517, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd1000, 1'b0);
    send_sample(10'd0, 1'b0);

    // Calibration request, then a second request while calibrating
    send_sample(10'd5, 1'b1);
    send_sample(10'd700, 1'b0);
    send_sample(10'd1, 1'b0);
    send_sample(10'd1023, 1'b1);
    send_sample(10'd300, 1'b0);

    // Largest counts, then lower each one partway through its phase
    write_reg(CFG_AMBIENT_SAMPLES, 12'hFFF);
    write_reg(CFG_DEAD_TICKS, 12'hFFF);
    write_reg(CFG_IR_SAMPLES, 12'hFFF);
    write_reg(CFG_TOLERANCE, 12'hFFF);
    repeat (3) send_sample(10'd1023, 1'b0);
    write_reg(CFG_AMBIENT_SAMPLES, 12'd1);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b0);
    // A zero count behaves as one
    write_reg(CFG_DEAD_TICKS, 12'd0);
    send_sample(10'd0, 1'b0);
    repeat (3) send_sample(10'd1023, 1'b0);
    write_reg(CFG_IR_SAMPLES, 12'd1);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b0);

    // Random blocks: new settings, then mostly plausible light levels
    for (int blk = 0; blk < 10; blk++) begin
      sel = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
        if (i == sel || $urandom_range(0, 1) == 1) begin
          idx = cfg_idx_t'(i);
          if (idx == CFG_TOLERANCE)
            val = ($urandom_range(0, 2) == 0) ? COUNT_BITS'($urandom_range(0, 4095))
                                              : COUNT_BITS'($urandom_range(0, 15));
          else
            val = ($urandom_range(0, 99) < 85) ? COUNT_BITS'($urandom_range(0, 7))
                                               : COUNT_BITS'($urandom_range(8, 40));
          write_reg(idx, val);
        end
      end
      lo   = ADC_BITS'($urandom_range(0, 500));
      hi   = ADC_BITS'($urandom_range(lo, 1008));
      calm = (blk == 4);
      for (int k = 0; k < 80; k++) begin
        if (blk == 6 && k == 40) wait_drained();
        if ($urandom_range(0, 4) == 0) adc = ADC_BITS'($urandom_range(0, 1023));
        else adc = ((book.ph == PH_IR) ? hi : lo) + ADC_BITS'($urandom_range(0, 15));
        send_sample(adc, (k == 0 && $urandom_range(0, 2) == 0) ||
                         $urandom_range(0, 299) == 0);
      end
      calm = 1'b0;
    end

    // Drain and watch for stray readings
    wait_drained();
    repeat (TAIL) @(negedge clk);

    $display("run covered %0d ticks, %0d readings checked, %0d closed cycles,",
             book.taken, book.checked, book.closed);
    $display("%0d finished calibrations and %0d register writes",
             book.cal_runs, book.writes);
    if (book.errors == 0 && book.due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
